// ===== sv/sexagesimal_angle_alu_defines.svh =====
// Assertion macros shared by the checkers of the sexagesimal angle ALU.
// Uses the clk and rst_n names of the scope that expands them.
`ifndef SEXAGESIMAL_ANGLE_ALU_DEFINES_SVH
`define SEXAGESIMAL_ANGLE_ALU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/saa_pkg.sv =====
// Shared types and constants of the sexagesimal angle ALU.
// No dependencies; every file but the assertion header refers to it by scoped names.
package saa_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_CMP = 2'd3
    } saa_op_t;

    // Operation and comparison flags that follow an item through the back end.
    typedef struct packed {
        saa_op_t op;
        logic    lt;
        logic    eq;
        logic    gt;
    } saa_ctrl_t;

    localparam int unsigned FIELD_BITS = 6;
    localparam int unsigned SEX_BASE   = 60;
    localparam int unsigned BASE_MAX   = 59;

    // Subtraction works on biased digits so that every partial stays unsigned.
    // The seconds bias of two bases is removed again by the minutes bias,
    // which is two short of two bases; degrees carry the remaining offset.
    localparam int unsigned SUB_SEC_BIAS = 120;
    localparam int unsigned SUB_MIN_BIAS = 118;
    localparam int unsigned SUB_DEG_LOW  = 2;

    // Depth of the queue between the front and the back; a power of two.
    localparam int unsigned QDEPTH = 2;

    function automatic int unsigned max_of(input int unsigned x, input int unsigned y);
        return (x > y) ? x : y;
    endfunction

endpackage

// ===== sv/saa_div60.sv =====
// Divides an unsigned value by 60 with a reciprocal multiply and one correction.
// Depends on saa_pkg for the base constant.
module saa_div60 #(
    parameter int unsigned W = 8
) (
    input  logic [W-1:0] x,
    output logic [W-6:0] q,
    output logic [5:0]   r
);

    localparam int unsigned MW = W - 5;
    localparam int unsigned PW = W + MW;
    localparam logic [MW-1:0] RECIP = MW'((2 ** W) / saa_pkg::SEX_BASE);

    logic [PW-1:0] prod;
    logic [MW-1:0] q_est;
    logic [W-1:0]  q_times;
    logic [6:0]    r_est;
    logic          fix;

    // The estimate is the true quotient or one below it, so the remainder
    // stays under two bases and a single subtract settles it.
    assign prod    = PW'(x) * PW'(RECIP);
    assign q_est   = prod[PW-1:W];
    assign q_times = W'(q_est) * W'(saa_pkg::SEX_BASE);
    assign r_est   = 7'(x - q_times);
    assign fix     = (r_est >= 7'(saa_pkg::SEX_BASE));
    assign q       = fix ? MW'(q_est + 1'b1) : q_est;
    assign r       = fix ? 6'(r_est - 7'(saa_pkg::SEX_BASE)) : 6'(r_est);

endmodule

// ===== sv/saa_front.sv =====
// Front end: takes operands from the input stream, compares them and forms
// the raw per-digit partials for the back end. Depends on saa_pkg.
module saa_front #(
    parameter int unsigned DEGREE_BITS = 16,
    parameter int unsigned FACTOR_BITS = 8
) (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // a_degrees, a_minutes, a_seconds, b_degrees, b_minutes, b_seconds, factor
    input  logic [((2*DEGREE_BITS+24+FACTOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic [1:0]                        s_axis_tuser,
    input  logic                              q_full,
    output logic                              push,
    output saa_pkg::saa_ctrl_t                ctrl,
    output logic [saa_pkg::max_of(8, 6+FACTOR_BITS)-1:0]   s_raw,
    output logic [saa_pkg::max_of(8, 6+FACTOR_BITS):0]     m_raw,
    output logic [saa_pkg::max_of(DEGREE_BITS+FACTOR_BITS, DEGREE_BITS+1)+1:0] d_raw
);

    localparam int unsigned D  = DEGREE_BITS;
    localparam int unsigned F  = FACTOR_BITS;
    localparam int unsigned FB = saa_pkg::FIELD_BITS;
    localparam int unsigned WS = saa_pkg::max_of(8, 6 + F);
    localparam int unsigned WM = WS + 1;
    localparam int unsigned WD = saa_pkg::max_of(D + F, D + 1) + 2;

    localparam int unsigned A_MIN_LO = D;
    localparam int unsigned A_SEC_LO = D + FB;
    localparam int unsigned B_DEG_LO = D + 2 * FB;
    localparam int unsigned B_MIN_LO = 2 * D + 2 * FB;
    localparam int unsigned B_SEC_LO = 2 * D + 3 * FB;
    localparam int unsigned FAC_LO   = 2 * D + 4 * FB;

    logic [D-1:0]  a_degrees;
    logic [FB-1:0] a_minutes;
    logic [FB-1:0] a_seconds;
    logic [D-1:0]  b_degrees;
    logic [FB-1:0] b_minutes;
    logic [FB-1:0] b_seconds;
    logic [F-1:0]  factor;
    logic          lt;
    logic          eq;

    assign a_degrees = s_axis_tdata[D-1:0];
    assign a_minutes = s_axis_tdata[A_MIN_LO +: FB];
    assign a_seconds = s_axis_tdata[A_SEC_LO +: FB];
    assign b_degrees = s_axis_tdata[B_DEG_LO +: D];
    assign b_minutes = s_axis_tdata[B_MIN_LO +: FB];
    assign b_seconds = s_axis_tdata[B_SEC_LO +: FB];
    assign factor    = s_axis_tdata[FAC_LO +: F];

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    // The flags compare the raw fields, degrees first, then minutes, then seconds.
    assign eq = (a_degrees == b_degrees) && (a_minutes == b_minutes)
             && (a_seconds == b_seconds);
    assign lt = (a_degrees < b_degrees)
             || ((a_degrees == b_degrees)
                 && ((a_minutes < b_minutes)
                     || ((a_minutes == b_minutes) && (a_seconds < b_seconds))));

    always_comb
    begin
        ctrl.op = saa_pkg::saa_op_t'(s_axis_tuser);
        ctrl.lt = lt;
        ctrl.eq = eq;
        ctrl.gt = !lt && !eq;
    end

    always_comb
    begin
        s_raw = '0;
        m_raw = '0;
        d_raw = '0;
        case (ctrl.op)
            saa_pkg::OP_ADD:
            begin
                s_raw = WS'(a_seconds) + WS'(b_seconds);
                m_raw = WM'(a_minutes) + WM'(b_minutes);
                d_raw = WD'(a_degrees) + WD'(b_degrees);
            end
            saa_pkg::OP_SUB:
            begin
                s_raw = WS'(a_seconds) + WS'(saa_pkg::SUB_SEC_BIAS) - WS'(b_seconds);
                m_raw = WM'(a_minutes) + WM'(saa_pkg::SUB_MIN_BIAS) - WM'(b_minutes);
                // Degrees are offset by 2^D so the difference cannot wrap.
                d_raw = WD'(a_degrees) + (WD'(1) << D) - WD'(b_degrees);
            end
            saa_pkg::OP_MUL:
            begin
                s_raw = WS'(a_seconds) * WS'(factor);
                m_raw = WM'(a_minutes) * WM'(factor);
                d_raw = WD'(a_degrees) * WD'(factor);
            end
            default:
            begin
                s_raw = '0;
                m_raw = '0;
                d_raw = '0;
            end
        endcase
    end

endmodule

// ===== sv/saa_queue.sv =====
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on saa_pkg for its depth.
module saa_queue #(
    parameter int unsigned W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         full,
    output logic         rvalid,
    output logic [W-1:0] rdata
);

    localparam int unsigned DEPTH = saa_pkg::QDEPTH;
    localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full   = (count_reg == CW'(DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/saa_back.sv =====
// Back end: normalizes seconds, then minutes and degrees, and holds the result
// in the output register. Depends on saa_pkg and saa_div60.
module saa_back #(
    parameter int unsigned DEGREE_BITS = 16,
    parameter int unsigned FACTOR_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  saa_pkg::saa_ctrl_t   q_ctrl,
    input  logic [saa_pkg::max_of(8, 6+FACTOR_BITS)-1:0]   q_s_raw,
    input  logic [saa_pkg::max_of(8, 6+FACTOR_BITS):0]     q_m_raw,
    input  logic [saa_pkg::max_of(DEGREE_BITS+FACTOR_BITS, DEGREE_BITS+1)+1:0] q_d_raw,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // r_degrees, r_minutes, r_seconds, overflow, a_less, a_equal, a_greater
    output logic [((DEGREE_BITS+16+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned D     = DEGREE_BITS;
    localparam int unsigned F     = FACTOR_BITS;
    localparam int unsigned FB    = saa_pkg::FIELD_BITS;
    localparam int unsigned WS    = saa_pkg::max_of(8, 6 + F);
    localparam int unsigned WM    = WS + 1;
    localparam int unsigned WD    = saa_pkg::max_of(D + F, D + 1) + 2;
    localparam int unsigned OUT_W = ((D + 16 + 7) / 8) * 8;

    localparam logic [WD-1:0] DEG_MAX   = WD'({D{1'b1}});
    localparam logic [WD-1:0] SUB_FLOOR = (WD'(1) << D) + WD'(saa_pkg::SUB_DEG_LOW);

    // Stage 1 registers.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    saa_pkg::saa_ctrl_t s1_ctrl_reg;
    logic [WM-1:0]      s1_m_reg;
    logic [FB-1:0]      s1_sec_reg;
    logic [WD-1:0]      s1_d_reg;

    // Output registers.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [D-1:0]       out_deg_reg;
    logic [FB-1:0]      out_min_reg;
    logic [FB-1:0]      out_sec_reg;
    logic               out_ovf_reg;
    saa_pkg::saa_ctrl_t out_ctrl_reg;

    logic               out_free;
    logic               s1_load;
    logic [WS-6:0]      sec_carry;
    logic [FB-1:0]      sec_rem;
    logic [WM-1:0]      m_sum;
    logic [WM-6:0]      min_carry;
    logic [FB-1:0]      min_rem;
    logic [WD-1:0]      d_sum;
    logic [WD-1:0]      d_val;
    logic               clamp;
    logic               sat;
    logic [D-1:0]       r_deg;
    logic [FB-1:0]      r_min;
    logic [FB-1:0]      r_sec;
    logic               r_ovf;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s1_load  = !s1_valid_reg || out_free;
    assign q_pop    = q_valid && s1_load;

    assign s1_valid_next  = s1_load ? q_valid : s1_valid_reg;
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    saa_div60 #(.W(WS)) u_sec_div (
        .x (q_s_raw),
        .q (sec_carry),
        .r (sec_rem)
    );

    assign m_sum = q_m_raw + WM'(sec_carry);

    saa_div60 #(.W(WM)) u_min_div (
        .x (s1_m_reg),
        .q (min_carry),
        .r (min_rem)
    );

    assign d_sum = s1_d_reg + WD'(min_carry);

    always_comb
    begin
        clamp = 1'b0;
        d_val = d_sum;
        case (s1_ctrl_reg.op)
            saa_pkg::OP_SUB:
            begin
                // Below the floor the difference is negative: a was less than b.
                clamp = (d_sum < SUB_FLOOR);
                d_val = d_sum - SUB_FLOOR;
            end
            saa_pkg::OP_CMP:
            begin
                clamp = 1'b1;
            end
            default:
            begin
                clamp = 1'b0;
                d_val = d_sum;
            end
        endcase
        sat = !clamp && (d_val > DEG_MAX);
    end

    always_comb
    begin
        if (clamp)
        begin
            r_deg = '0;
            r_min = '0;
            r_sec = '0;
            r_ovf = 1'b0;
        end
        else if (sat)
        begin
            r_deg = '1;
            r_min = FB'(saa_pkg::BASE_MAX);
            r_sec = FB'(saa_pkg::BASE_MAX);
            r_ovf = 1'b1;
        end
        else
        begin
            r_deg = d_val[D-1:0];
            r_min = min_rem;
            r_sec = s1_sec_reg;
            r_ovf = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_ctrl_reg <= q_ctrl;
            s1_m_reg    <= m_sum;
            s1_sec_reg  <= sec_rem;
            s1_d_reg    <= q_d_raw;
        end
        if (out_free && s1_valid_reg)
        begin
            out_deg_reg  <= r_deg;
            out_min_reg  <= r_min;
            out_sec_reg  <= r_sec;
            out_ovf_reg  <= r_ovf;
            out_ctrl_reg <= s1_ctrl_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_ctrl_reg.gt, out_ctrl_reg.eq, out_ctrl_reg.lt,
                                   out_ovf_reg, out_sec_reg, out_min_reg, out_deg_reg});

endmodule

// ===== sv/sexagesimal_angle_alu.sv =====
// Top level of the sexagesimal angle ALU: front end, queue and back end.
// Depends on saa_pkg, saa_front, saa_queue, saa_back and saa_div60.
//
//   Channel   Direction  Carries
//   s_axis    in         tuser: opcode; tdata: both operands and the factor
//   m_axis    out        tdata: result digits, overflow and compare flags
//
// One item is accepted every cycle while the queue has room; the queue and the
// two back-end stages hold no shared unit, so while m_axis_tready is high the sustained rate is one per cycle.
// An accepted item passes through a queue slot, stage 1 and the output register.
// Reset clears the queue pointers and count and the stage valid bits; nothing else is kept.
// With m_axis_tready low the output register holds, stage 1 and then the
// two-entry queue fill, and s_axis_tready drops once both queue entries wait.
module sexagesimal_angle_alu #(
    parameter int unsigned DEGREE_BITS = 16,
    parameter int unsigned FACTOR_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_degrees, a_minutes, a_seconds, b_degrees, b_minutes, b_seconds, factor
    input  logic [((2*DEGREE_BITS+24+FACTOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // r_degrees, r_minutes, r_seconds, overflow, a_less, a_equal, a_greater
    output logic [((DEGREE_BITS+16+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned D      = DEGREE_BITS;
    localparam int unsigned F      = FACTOR_BITS;
    localparam int unsigned WS     = saa_pkg::max_of(8, 6 + F);
    localparam int unsigned WM     = WS + 1;
    localparam int unsigned WD     = saa_pkg::max_of(D + F, D + 1) + 2;
    localparam int unsigned CTRL_W = $bits(saa_pkg::saa_ctrl_t);
    localparam int unsigned Q_W    = CTRL_W + WS + WM + WD;

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [Q_W-1:0]     q_wdata;
    logic [Q_W-1:0]     q_rdata;
    saa_pkg::saa_ctrl_t f_ctrl;
    logic [WS-1:0]      f_s_raw;
    logic [WM-1:0]      f_m_raw;
    logic [WD-1:0]      f_d_raw;
    saa_pkg::saa_ctrl_t b_ctrl;
    logic [WS-1:0]      b_s_raw;
    logic [WM-1:0]      b_m_raw;
    logic [WD-1:0]      b_d_raw;

    saa_front #(
        .DEGREE_BITS (DEGREE_BITS),
        .FACTOR_BITS (FACTOR_BITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .ctrl          (f_ctrl),
        .s_raw         (f_s_raw),
        .m_raw         (f_m_raw),
        .d_raw         (f_d_raw)
    );

    assign q_wdata = {f_ctrl, f_s_raw, f_m_raw, f_d_raw};

    saa_queue #(.W(Q_W)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .full   (q_full),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    assign b_ctrl  = saa_pkg::saa_ctrl_t'(q_rdata[Q_W-1 -: CTRL_W]);
    assign b_s_raw = q_rdata[WM+WD +: WS];
    assign b_m_raw = q_rdata[WD +: WM];
    assign b_d_raw = q_rdata[WD-1:0];

    saa_back #(
        .DEGREE_BITS (DEGREE_BITS),
        .FACTOR_BITS (FACTOR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_ctrl        (b_ctrl),
        .q_s_raw       (b_s_raw),
        .q_m_raw       (b_m_raw),
        .q_d_raw       (b_d_raw),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== sv/saa_checker.sv =====
// Port-level checks on the result stream of the sexagesimal angle ALU.
// Depends on sexagesimal_angle_alu_defines.svh and saa_pkg; bound to the top level.
`include "sexagesimal_angle_alu_defines.svh"

module saa_checker #(
    parameter int unsigned DEGREE_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((DEGREE_BITS+16+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned D  = DEGREE_BITS;
    localparam int unsigned FB = saa_pkg::FIELD_BITS;

    logic [D-1:0]  r_degrees;
    logic [FB-1:0] r_minutes;
    logic [FB-1:0] r_seconds;
    logic          overflow;
    logic          a_less;
    logic          a_equal;
    logic          a_greater;

    assign r_degrees = m_axis_tdata[D-1:0];
    assign r_minutes = m_axis_tdata[D +: FB];
    assign r_seconds = m_axis_tdata[D+FB +: FB];
    assign overflow  = m_axis_tdata[D+2*FB];
    assign a_less    = m_axis_tdata[D+2*FB+1];
    assign a_equal   = m_axis_tdata[D+2*FB+2];
    assign a_greater = m_axis_tdata[D+2*FB+3];

    `SAA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    `SAA_ASSERT_SAME(a_flags_onehot, m_axis_tvalid, $onehot({a_less, a_equal, a_greater}), "compare flags are not exactly one")

    `SAA_ASSERT_SAME(a_digits_norm, m_axis_tvalid, (r_minutes <= FB'(saa_pkg::BASE_MAX)) && (r_seconds <= FB'(saa_pkg::BASE_MAX)), "result digits not normalized")

    `SAA_ASSERT_SAME(a_ovf_sat, m_axis_tvalid && overflow, (r_degrees == {D{1'b1}}) && (r_minutes == FB'(saa_pkg::BASE_MAX)) && (r_seconds == FB'(saa_pkg::BASE_MAX)), "overflow without saturated result")

endmodule

bind sexagesimal_angle_alu saa_checker #(
    .DEGREE_BITS (DEGREE_BITS)
) u_saa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_sexagesimal_angle_alu.sv =====
// Self-checking testbench for sexagesimal_angle_alu: directed and random angle operations
// go through the stream ports under varied idling, and every result is checked against a
// local degrees-minutes-seconds predictor. Depends on saa_pkg and the RTL of the block.
module tb_sexagesimal_angle_alu;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEG_W       = 16;
    localparam int unsigned FAC_W       = 8;
    localparam int unsigned FIELD_BITS  = saa_pkg::FIELD_BITS;
    localparam int unsigned BASE_MAX    = saa_pkg::BASE_MAX;
    localparam int unsigned SEX_BASE    = saa_pkg::SEX_BASE;
    localparam int unsigned DEG_MAX     = (1 << DEG_W) - 1;
    localparam int unsigned SECS_IN_DEG = 3600;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Operand fields in tdata order, lowest field last in the declaration.
    typedef struct packed {
        logic [FAC_W-1:0]      fac;
        logic [FIELD_BITS-1:0] b_sec;
        logic [FIELD_BITS-1:0] b_min;
        logic [DEG_W-1:0]      b_deg;
        logic [FIELD_BITS-1:0] a_sec;
        logic [FIELD_BITS-1:0] a_min;
        logic [DEG_W-1:0]      a_deg;
    } angle_pair_t;

    typedef struct packed {
        logic                  gt;
        logic                  eq;
        logic                  lt;
        logic                  ovf;
        logic [FIELD_BITS-1:0] r_sec;
        logic [FIELD_BITS-1:0] r_min;
        logic [DEG_W-1:0]      r_deg;
    } angle_res_t;

    typedef struct {
        saa_pkg::saa_op_t op;
        angle_pair_t      pair;
    } angle_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // a_degrees, a_minutes, a_seconds, b_degrees, b_minutes, b_seconds, factor
    logic [63:0] s_axis_tdata = '0;
    // opcode
    logic [1:0]  s_axis_tuser = saa_pkg::OP_ADD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // r_degrees, r_minutes, r_seconds, overflow, a_less, a_equal, a_greater
    logic [31:0] m_axis_tdata;

    angle_cmd_t  cmds_to_send[$];
    angle_res_t  angles_due[$];
    angle_cmd_t  next_cmd;
    angle_res_t  want_res;
    angle_res_t  got_res;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_served;
    int unsigned hold_left;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned transfers_in = 0;
    int unsigned results_checked = 0;
    int unsigned saturations = 0;
    int unsigned op_counts[4] = '{0, 0, 0, 0};

    sexagesimal_angle_alu #(
        .DEGREE_BITS(DEG_W),
        .FACTOR_BITS(FAC_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Works on total seconds, then splits back into degrees, minutes and seconds.
    function automatic angle_res_t dms_predict(saa_pkg::saa_op_t op, angle_pair_t p);
        longint unsigned total_a;
        longint unsigned total_b;
        longint unsigned total_r;
        longint unsigned deg;
        longint unsigned rem;
        bit              split;
        angle_res_t      r;
        total_a = p.a_deg * 64'd3600 + p.a_min * 64'd60 + p.a_sec;
        total_b = p.b_deg * 64'd3600 + p.b_min * 64'd60 + p.b_sec;
        r = '0;
        split = 1'b1;
        total_r = 0;
        case (op)
            saa_pkg::OP_ADD: total_r = total_a + total_b;
            saa_pkg::OP_SUB:
            begin
                if (total_a >= total_b)
                    total_r = total_a - total_b;
                else
                    split = 1'b0;
            end
            saa_pkg::OP_MUL: total_r = total_a * p.fac;
            default: split = 1'b0;
        endcase
        if (split)
        begin
            deg = total_r / SECS_IN_DEG;
            rem = total_r % SECS_IN_DEG;
            if (deg > DEG_MAX)
            begin
                r.r_deg = DEG_W'(DEG_MAX);
                r.r_min = FIELD_BITS'(BASE_MAX);
                r.r_sec = FIELD_BITS'(BASE_MAX);
                r.ovf   = 1'b1;
            end
            else
            begin
                r.r_deg = DEG_W'(deg);
                r.r_min = FIELD_BITS'(rem / SEX_BASE);
                r.r_sec = FIELD_BITS'(rem % SEX_BASE);
            end
        end
        // The flags compare the raw fields, most significant field first.
        if (p.a_deg != p.b_deg)
            r.lt = p.a_deg < p.b_deg;
        else if (p.a_min != p.b_min)
            r.lt = p.a_min < p.b_min;
        else
            r.lt = p.a_sec < p.b_sec;
        r.eq = (p.a_deg == p.b_deg) && (p.a_min == p.b_min) && (p.a_sec == p.b_sec);
        r.gt = !r.lt && !r.eq;
        return r;
    endfunction

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_cmd(saa_pkg::saa_op_t op, int unsigned ad, int unsigned am,
                             int unsigned asec, int unsigned bd, int unsigned bm,
                             int unsigned bsec, int unsigned fac);
        angle_cmd_t c;
        c.op = op;
        c.pair.a_deg = DEG_W'(ad);
        c.pair.a_min = FIELD_BITS'(am);
        c.pair.a_sec = FIELD_BITS'(asec);
        c.pair.b_deg = DEG_W'(bd);
        c.pair.b_min = FIELD_BITS'(bm);
        c.pair.b_sec = FIELD_BITS'(bsec);
        c.pair.fac = FAC_W'(fac);
        cmds_to_send.push_back(c);
    endtask

    function automatic logic [DEG_W-1:0] random_degrees();
        int unsigned pick;
        pick = $urandom_range(7);
        case (pick)
            0: return '0;
            1: return DEG_W'(DEG_MAX);
            2: return DEG_W'($urandom_range(3));
            3: return DEG_W'(DEG_MAX - $urandom_range(300));
            default: return DEG_W'($urandom);
        endcase
    endfunction

    // Mostly 0..59; now and then one of the out-of-range codes 60..63.
    function automatic logic [FIELD_BITS-1:0] random_sixty();
        if ($urandom_range(9) == 0)
            return FIELD_BITS'($urandom_range(63, 60));
        return FIELD_BITS'($urandom_range(BASE_MAX));
    endfunction

    function automatic angle_cmd_t random_cmd();
        angle_cmd_t c;
        int unsigned relation;
        int unsigned fac_pick;
        c.op = saa_pkg::saa_op_t'($urandom_range(3));
        c.pair.a_deg = random_degrees();
        c.pair.a_min = random_sixty();
        c.pair.a_sec = random_sixty();
        c.pair.b_deg = random_degrees();
        c.pair.b_min = random_sixty();
        c.pair.b_sec = random_sixty();
        // Bias toward operands that tie on the upper fields so every flag path is hit.
        relation = $urandom_range(9);
        if (relation <= 1)
        begin
            c.pair.b_deg = c.pair.a_deg;
            c.pair.b_min = c.pair.a_min;
            c.pair.b_sec = c.pair.a_sec;
        end
        else if (relation == 2)
        begin
            c.pair.b_deg = c.pair.a_deg;
            c.pair.b_min = c.pair.a_min;
        end
        else if (relation == 3)
            c.pair.b_deg = c.pair.a_deg;
        fac_pick = $urandom_range(7);
        if (fac_pick == 0)
            c.pair.fac = '0;
        else if (fac_pick == 1)
            c.pair.fac = FAC_W'(1);
        else if (fac_pick == 2)
            c.pair.fac = '1;
        else
            c.pair.fac = FAC_W'($urandom);
        return c;
    endfunction

    task automatic queue_random(int unsigned count);
        repeat (count) cmds_to_send.push_back(random_cmd());
    endtask

    // Waits until every queued command has been taken and, if asked, every result checked.
    task automatic wait_drain(bit results_too);
        while (cmds_to_send.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        if (results_too)
            while (angles_due.size() != 0)
                @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= saa_pkg::OP_ADD;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (cmds_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd = cmds_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_cmd.pair;
                s_axis_tuser <= next_cmd.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            holds_served <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_asked;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Results are checked before the new expectation is queued, which is safe since
    // a result never leaves in the cycle its transfer is accepted.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = angle_res_t'(m_axis_tdata);
            if (angles_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_res = angles_due.pop_front();
                compare_field("r_degrees", want_res.r_deg, got_res.r_deg);
                compare_field("r_minutes", want_res.r_min, got_res.r_min);
                compare_field("r_seconds", want_res.r_sec, got_res.r_sec);
                compare_field("overflow", want_res.ovf, got_res.ovf);
                compare_field("a_less", want_res.lt, got_res.lt);
                compare_field("a_equal", want_res.eq, got_res.eq);
                compare_field("a_greater", want_res.gt, got_res.gt);
                results_checked++;
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            want_res = dms_predict(saa_pkg::saa_op_t'(s_axis_tuser),
                                   angle_pair_t'(s_axis_tdata));
            angles_due.push_back(want_res);
            transfers_in++;
            op_counts[s_axis_tuser]++;
            if (want_res.ovf)
                saturations++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     angles_due.size());
            $display("sexagesimal_angle_alu verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Carries, saturation edges, clamping, raw codes 60..63 and every flag outcome.
        queue_cmd(saa_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(saa_pkg::OP_ADD, 10, 59, 59, 0, 0, 1, 0);
        queue_cmd(saa_pkg::OP_ADD, DEG_MAX, 59, 59, 0, 0, 0, 0);
        queue_cmd(saa_pkg::OP_ADD, DEG_MAX, 59, 59, 0, 0, 1, 0);
        queue_cmd(saa_pkg::OP_ADD, DEG_MAX, 59, 59, DEG_MAX, 59, 59, 255);
        queue_cmd(saa_pkg::OP_ADD, 0, 63, 63, 0, 63, 63, 0);
        queue_cmd(saa_pkg::OP_SUB, 5, 0, 0, 5, 0, 0, 0);
        queue_cmd(saa_pkg::OP_SUB, 5, 0, 0, 4, 59, 59, 0);
        queue_cmd(saa_pkg::OP_SUB, 4, 59, 59, 5, 0, 0, 0);
        queue_cmd(saa_pkg::OP_SUB, DEG_MAX, 59, 59, 0, 0, 0, 0);
        queue_cmd(saa_pkg::OP_SUB, 0, 63, 0, 1, 0, 0, 0);
        queue_cmd(saa_pkg::OP_SUB, 1, 0, 0, 0, 63, 0, 0);
        queue_cmd(saa_pkg::OP_MUL, 1, 2, 3, 0, 0, 0, 0);
        queue_cmd(saa_pkg::OP_MUL, 0, 0, 59, 0, 0, 0, 2);
        queue_cmd(saa_pkg::OP_MUL, DEG_MAX, 59, 59, 0, 0, 0, 255);
        queue_cmd(saa_pkg::OP_MUL, 257, 0, 0, 0, 0, 0, 255);
        queue_cmd(saa_pkg::OP_MUL, 12, 34, 56, 3, 4, 5, 1);
        queue_cmd(saa_pkg::OP_MUL, 0, 63, 63, 0, 0, 0, 255);
        queue_cmd(saa_pkg::OP_CMP, 7, 8, 9, 7, 8, 9, 0);
        queue_cmd(saa_pkg::OP_CMP, 7, 8, 9, 8, 0, 0, 0);
        queue_cmd(saa_pkg::OP_CMP, 7, 8, 9, 7, 9, 0, 0);
        queue_cmd(saa_pkg::OP_CMP, 7, 8, 10, 7, 8, 9, 0);
        queue_cmd(saa_pkg::OP_CMP, DEG_MAX, 63, 63, 0, 0, 0, 255);
        wait_drain(1'b1);

        // Back-to-back transfers; the long receiver hold-off lets the block fill and stall.
        queue_random(100);
        holds_asked++;
        wait_drain(1'b1);

        send_idle_pct = 81;
        queue_random(100);
        wait_drain(1'b0);

        send_idle_pct = 0;
        stall_pct = 81;
        queue_random(100);
        wait_drain(1'b0);

        send_idle_pct = 35;
        stall_pct = 35;
        queue_random(130);
        wait_drain(1'b1);

        repeat (DRAIN_WAIT) @(negedge clk);
        $display("Ran %0d transfers (add %0d, sub %0d, mul %0d, cmp %0d), %0d saturated.",
                 transfers_in, op_counts[saa_pkg::OP_ADD], op_counts[saa_pkg::OP_SUB],
                 op_counts[saa_pkg::OP_MUL], op_counts[saa_pkg::OP_CMP], saturations);
        $display("Checked %0d results across four idling phases and one long output stall.",
                 results_checked);
        if (mismatches == 0 && angles_due.size() == 0)
            $display("sexagesimal_angle_alu verification clean");
        else
            $display("sexagesimal_angle_alu verification failed");
        $finish;
    end

endmodule
